// ===== rtl/core/arls_pkg.sv =====
// Shared types and constants for the response line sorter.
package arls_pkg;

   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_R       = 8'h52;
   localparam logic [7:0] CH_S       = 8'h53;
   localparam logic [7:0] CH_W       = 8'h57;
   localparam logic [7:0] CH_O       = 8'h4F;
   localparam logic [7:0] CH_F       = 8'h46;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_FOUR    = 8'h34;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam logic [7:0] IDLE_RELOAD_RESET = 8'd5;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic BUF_ANSWER = 1'b0;
   localparam logic BUF_PACKET = 1'b1;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_ANS_READY = 3'd1;
   localparam logic [2:0] EV_PKT_READY = 3'd2;
   localparam logic [2:0] EV_ANS_OVF   = 3'd3;
   localparam logic [2:0] EV_PKT_OVF   = 3'd4;

   typedef struct packed {
      logic answer_open;
      logic packet_open;
      logic newline;
   } class_type;

endpackage

// ===== rtl/core/arls_classify.sv =====
// Byte classifier: recognises line openers and the newline.
module arls_classify (
   input  logic [7:0]           byte_value,
   output arls_pkg::class_type  cls
);
   import arls_pkg::*;

   always_comb begin
      cls.answer_open = byte_value inside {CH_A, CH_R, CH_S, CH_W, CH_O, CH_F, CH_C};
      cls.packet_open = (byte_value inside {[CH_ZERO:CH_FOUR]}) || (byte_value == CH_PLUS);
      cls.newline     = (byte_value == CH_NEWLINE);
   end

endmodule

// ===== rtl/core/at_response_line_sorter.sv =====
// Top level of the response line sorter: input register, line step and result register.
//
// Accepts one item (a received byte or a timer tick) per clock while req_stall is low, and
// gives exactly one result per item. An item passes through the input register, the single
// combinational step that updates the line state, and the result register; the step keeps
// no loop, so items follow one another in consecutive cycles unless a stall holds them.
// A result waiting in the output register blocks the input only once the input register
// also holds an item. The idle reload register is written through the csr_ channel, which
// is always ready, and should be written only while the block holds no item.
module at_response_line_sorter #(
   parameter int ANSWER_DEPTH = 256,
   parameter int PACKET_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_write_enable,
   output logic       rsp_target_buffer,
   output logic [7:0] rsp_write_addr,
   output logic [7:0] rsp_write_data,
   output logic [2:0] rsp_event_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   import arls_pkg::*;

   localparam logic [8:0] ANS_DEPTH_W = 9'(ANSWER_DEPTH);
   localparam logic [8:0] PKT_DEPTH_W = 9'(PACKET_DEPTH);
   localparam logic [7:0] ANS_LAST    = 8'(ANSWER_DEPTH - 1);
   localparam logic [7:0] PKT_LAST    = 8'(PACKET_DEPTH - 1);

   logic [7:0] reload_ff;

   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   logic       answer_active_ff, answer_active_in;
   logic       answer_finished_ff, answer_finished_in;
   logic       packet_active_ff, packet_active_in;
   logic       packet_finished_ff, packet_finished_in;
   logic [7:0] write_index_ff, write_index_in;
   logic       last_target_ff, last_target_in;
   logic [7:0] idle_count_ff, idle_count_in;

   logic       out_valid_ff;
   logic       out_we_ff, out_we_in;
   logic       out_tgt_ff, out_tgt_in;
   logic [7:0] out_addr_ff, out_addr_in;
   logic [7:0] out_data_ff, out_data_in;
   logic [2:0] out_ev_ff, out_ev_in;

   logic       accept_in, advance;
   class_type  cls;

   // Line-byte helpers.
   logic       line_ans;
   logic [8:0] depth_w;
   logic [7:0] last_addr;
   logic [8:0] next_w;
   logic [7:0] dec_count;

   assign csr_ready = 1'b1;

   // The step runs when an item waits and the result register is free or emptying.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept_in = req_valid && !req_stall;
   assign in_valid_in = accept_in || (in_valid_ff && !advance);

   arls_classify u_classify (
      .byte_value (in_byte_ff),
      .cls        (cls)
   );

   always_comb begin
      answer_active_in   = answer_active_ff;
      answer_finished_in = answer_finished_ff;
      packet_active_in   = packet_active_ff;
      packet_finished_in = packet_finished_ff;
      write_index_in     = write_index_ff;
      last_target_in     = last_target_ff;
      idle_count_in      = idle_count_ff;
      out_we_in          = 1'b0;
      out_tgt_in         = BUF_ANSWER;
      out_addr_in        = 8'd0;
      out_data_in        = 8'd0;
      out_ev_in          = EV_NONE;

      line_ans  = answer_active_ff;
      depth_w   = line_ans ? ANS_DEPTH_W : PKT_DEPTH_W;
      last_addr = line_ans ? ANS_LAST : PKT_LAST;
      next_w    = {1'b0, write_index_ff} + 9'd1;
      dec_count = (idle_count_ff != 8'd0) ? idle_count_ff - 8'd1 : 8'd0;

      if (in_op_ff == OP_BYTE) begin
         idle_count_in = reload_ff;
         if (!answer_active_ff && !packet_active_ff) begin
            if (cls.answer_open) begin
               answer_active_in   = 1'b1;
               answer_finished_in = 1'b0;
               last_target_in     = BUF_ANSWER;
               write_index_in     = 8'd1;
               out_we_in          = 1'b1;
               out_tgt_in         = BUF_ANSWER;
               out_data_in        = in_byte_ff;
            end else if (cls.packet_open) begin
               packet_active_in   = 1'b1;
               packet_finished_in = 1'b0;
               last_target_in     = BUF_PACKET;
               write_index_in     = 8'd1;
               out_we_in          = 1'b1;
               out_tgt_in         = BUF_PACKET;
               out_data_in        = in_byte_ff;
            end
         end else begin
            if (cls.newline) begin
               if (line_ans) begin
                  answer_finished_in = 1'b1;
               end else begin
                  packet_finished_in = 1'b1;
               end
            end
            out_we_in   = 1'b1;
            out_tgt_in  = line_ans ? BUF_ANSWER : BUF_PACKET;
            out_data_in = in_byte_ff;
            out_addr_in = write_index_ff;
            if (next_w >= depth_w) begin
               // Buffer full: write the last entry and wrap the index.
               if ({1'b0, write_index_ff} >= depth_w) begin
                  out_addr_in = last_addr;
               end
               write_index_in = 8'd0;
               out_ev_in      = line_ans ? EV_ANS_OVF : EV_PKT_OVF;
            end else begin
               write_index_in = next_w[7:0];
            end
         end
      end else begin
         idle_count_in = dec_count;
         if (dec_count == 8'd0) begin
            if (answer_active_ff && answer_finished_ff) begin
               answer_active_in   = 1'b0;
               answer_finished_in = 1'b0;
               out_we_in          = 1'b1;
               out_tgt_in         = last_target_ff;
               out_addr_in        = write_index_ff;
               out_ev_in          = EV_ANS_READY;
            end else if (packet_active_ff && packet_finished_ff) begin
               packet_active_in   = 1'b0;
               packet_finished_in = 1'b0;
               out_we_in          = 1'b1;
               out_tgt_in         = last_target_ff;
               out_addr_in        = write_index_ff;
               out_ev_in          = EV_PKT_READY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff          <= IDLE_RELOAD_RESET;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         answer_active_ff   <= 1'b0;
         answer_finished_ff <= 1'b0;
         packet_active_ff   <= 1'b0;
         packet_finished_ff <= 1'b0;
         write_index_ff     <= 8'd0;
         last_target_ff     <= 1'b0;
         idle_count_ff      <= 8'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            reload_ff <= csr_data;
         end
         in_valid_ff <= in_valid_in;
         if (advance) begin
            out_valid_ff       <= 1'b1;
            answer_active_ff   <= answer_active_in;
            answer_finished_ff <= answer_finished_in;
            packet_active_ff   <= packet_active_in;
            packet_finished_ff <= packet_finished_in;
            write_index_ff     <= write_index_in;
            last_target_ff     <= last_target_in;
            idle_count_ff      <= idle_count_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_byte_value;
      end
      if (advance) begin
         out_we_ff   <= out_we_in;
         out_tgt_ff  <= out_tgt_in;
         out_addr_ff <= out_addr_in;
         out_data_ff <= out_data_in;
         out_ev_ff   <= out_ev_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_enable  = out_we_ff;
   assign rsp_target_buffer = out_tgt_ff;
   assign rsp_write_addr    = out_addr_ff;
   assign rsp_write_data    = out_data_ff;
   assign rsp_event_res     = out_ev_ff;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the response line sorter: directed table, then random lines.
module tb;
   import arls_pkg::*;

   localparam int SORTER_ANSWER_DEPTH = 256;
   localparam int SORTER_PACKET_DEPTH = 256;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 12;
   localparam int NUM_PHASES = 6;

   typedef struct packed {
      logic       wen;
      logic       target;
      logic [7:0] addr;
      logic [7:0] data;
      logic [2:0] ev;
   } line_write_type;

   typedef struct packed {
      logic           op;
      logic [7:0]     value;
      logic           fixed;
      line_write_type want;
   } stim_row_type;

   localparam line_write_type NO_WRITE = '0;
   localparam logic ROW_FIXED = 1'b1;
   localparam logic ROW_PREDICTED = 1'b0;

   // Walks one answer line and one packet line through to their ready events.
   localparam stim_row_type DIRECTED [24] = '{
      {OP_TICK, 8'hFF, ROW_FIXED, NO_WRITE},
      {OP_BYTE, 8'h78, ROW_FIXED, NO_WRITE},
      {OP_BYTE, CH_NEWLINE, ROW_FIXED, NO_WRITE},
      {OP_BYTE, CH_A, ROW_FIXED, {1'b1, BUF_ANSWER, 8'd0, CH_A, EV_NONE}},
      {OP_BYTE, 8'hFF, ROW_FIXED, {1'b1, BUF_ANSWER, 8'd1, 8'hFF, EV_NONE}},
      {OP_BYTE, 8'h00, ROW_FIXED, {1'b1, BUF_ANSWER, 8'd2, 8'h00, EV_NONE}},
      {OP_TICK, 8'h00, ROW_PREDICTED, NO_WRITE},
      {OP_BYTE, CH_NEWLINE, ROW_FIXED, {1'b1, BUF_ANSWER, 8'd3, CH_NEWLINE, EV_NONE}},
      {OP_TICK, 8'h5A, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'hA5, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'h00, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'hFF, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'h00, ROW_FIXED, {1'b1, BUF_ANSWER, 8'd4, 8'h00, EV_ANS_READY}},
      {OP_TICK, 8'h00, ROW_PREDICTED, NO_WRITE},
      {OP_BYTE, CH_PLUS, ROW_FIXED, {1'b1, BUF_PACKET, 8'd0, CH_PLUS, EV_NONE}},
      {OP_BYTE, CH_FOUR, ROW_PREDICTED, NO_WRITE},
      {OP_BYTE, CH_NEWLINE, ROW_PREDICTED, NO_WRITE},
      {OP_BYTE, CH_C, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'h11, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'h22, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'h44, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'h88, ROW_PREDICTED, NO_WRITE},
      {OP_TICK, 8'h00, ROW_FIXED, {1'b1, BUF_PACKET, 8'd4, 8'h00, EV_PKT_READY}},
      {OP_BYTE, CH_ZERO, ROW_PREDICTED, NO_WRITE}
   };

   localparam logic [7:0] ANSWER_OPENERS [7] = '{CH_A, CH_R, CH_S, CH_W, CH_O, CH_F, CH_C};
   localparam logic [7:0] PACKET_OPENERS [6] = '{CH_ZERO, CH_ZERO + 8'd1, CH_ZERO + 8'd2,
                                                 CH_ZERO + 8'd3, CH_FOUR, CH_PLUS};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_op = OP_BYTE;
   logic [7:0] req_byte_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_write_enable;
   logic       rsp_target_buffer;
   logic [7:0] rsp_write_addr;
   logic [7:0] rsp_write_data;
   logic [2:0] rsp_event_res;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // Own copy of the sorter state, advanced once per accepted input transfer.
   logic [7:0] reload_setting = IDLE_RELOAD_RESET;
   logic       ans_open = 1'b0;
   logic       ans_done = 1'b0;
   logic       pkt_open = 1'b0;
   logic       pkt_done = 1'b0;
   logic [7:0] next_addr = 8'd0;
   logic       open_target = BUF_ANSWER;
   logic [7:0] idle_left = 8'd0;

   line_write_type pending_writes [$];
   int bad_count = 0;
   int sent_count = 0;
   int cycle_count = 0;
   bit calm = 1'b0;

   at_response_line_sorter #(
      .ANSWER_DEPTH(SORTER_ANSWER_DEPTH),
      .PACKET_DEPTH(SORTER_PACKET_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_write_enable(rsp_write_enable),
      .rsp_target_buffer(rsp_target_buffer),
      .rsp_write_addr(rsp_write_addr),
      .rsp_write_data(rsp_write_data),
      .rsp_event_res(rsp_event_res),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 24);
      end
   end

   function automatic bit is_answer_opener(logic [7:0] b);
      case (b)
         CH_A, CH_R, CH_S, CH_W, CH_O, CH_F, CH_C: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic line_write_type sorted_write(logic op, logic [7:0] b);
      line_write_type w;
      int depth;
      w = NO_WRITE;
      if (op == OP_BYTE) begin
         if (!ans_open && !pkt_open) begin
            if (is_answer_opener(b)) begin
               ans_open = 1'b1;
               ans_done = 1'b0;
               open_target = BUF_ANSWER;
               next_addr = 8'd1;
               w = {1'b1, BUF_ANSWER, 8'd0, b, EV_NONE};
            end else if ((b >= CH_ZERO && b <= CH_FOUR) || b == CH_PLUS) begin
               pkt_open = 1'b1;
               pkt_done = 1'b0;
               open_target = BUF_PACKET;
               next_addr = 8'd1;
               w = {1'b1, BUF_PACKET, 8'd0, b, EV_NONE};
            end
         end else begin
            w.wen = 1'b1;
            w.target = ans_open ? BUF_ANSWER : BUF_PACKET;
            w.addr = next_addr;
            w.data = b;
            if (b == CH_NEWLINE) begin
               if (ans_open) ans_done = 1'b1;
               else pkt_done = 1'b1;
            end
            depth = ans_open ? SORTER_ANSWER_DEPTH : SORTER_PACKET_DEPTH;
            // A full buffer takes the byte at its last entry and the line starts again at 0.
            if (int'(next_addr) + 1 >= depth) begin
               if (int'(next_addr) >= depth) w.addr = 8'(depth - 1);
               next_addr = 8'd0;
               w.ev = ans_open ? EV_ANS_OVF : EV_PKT_OVF;
            end else begin
               next_addr = next_addr + 8'd1;
            end
         end
         idle_left = reload_setting;
      end else begin
         if (idle_left != 8'd0) idle_left = idle_left - 8'd1;
         if (idle_left == 8'd0) begin
            if (ans_open && ans_done) begin
               ans_open = 1'b0;
               ans_done = 1'b0;
               w = {1'b1, open_target, next_addr, 8'h00, EV_ANS_READY};
            end else if (pkt_open && pkt_done) begin
               pkt_open = 1'b0;
               pkt_done = 1'b0;
               w = {1'b1, open_target, next_addr, 8'h00, EV_PKT_READY};
            end
         end
      end
      return w;
   endfunction

   function automatic int ticks_to_report();
      return (reload_setting == 8'd0) ? 1 : int'(reload_setting);
   endfunction

   task automatic send_item(input logic op, input logic [7:0] b,
                            input logic fixed = ROW_PREDICTED,
                            input line_write_type want = NO_WRITE);
      line_write_type predicted;
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_byte_value <= b;
      do @(posedge clock); while (req_stall);
      predicted = sorted_write(op, b);
      pending_writes.push_back(fixed ? want : predicted);
      sent_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reload(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reload_setting = v;
   endtask

   task automatic spray_noise();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         if ($urandom_range(0, 2) == 0) begin
            send_item(1'($urandom_range(0, 1)), ($urandom_range(0, 1) == 1) ?
                      ANSWER_OPENERS[3'($urandom_range(0, 6))] :
                      PACKET_OPENERS[3'($urandom_range(0, 5))]);
         end else begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // One well-formed line: opener, body, newline, perhaps trailing bytes, then enough ticks.
   // A clean body carries neither newlines nor ticks, so long lines run into the buffer end.
   task automatic run_line(input logic which, input int body_len, input bit clean_body);
      logic [7:0] b;
      if (ans_open || pkt_open) begin
         send_item(OP_BYTE, CH_NEWLINE);
         repeat (ticks_to_report()) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
      if (which == BUF_ANSWER) send_item(OP_BYTE, ANSWER_OPENERS[3'($urandom_range(0, 6))]);
      else send_item(OP_BYTE, PACKET_OPENERS[3'($urandom_range(0, 5))]);
      for (int i = 0; i < body_len; i++) begin
         if (!clean_body && $urandom_range(0, 99) < 10) begin
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
         end else begin
            b = 8'($urandom_range(0, 255));
            if (clean_body && b == CH_NEWLINE) b = 8'h0B;
            send_item(OP_BYTE, b);
         end
      end
      send_item(OP_BYTE, CH_NEWLINE);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end
      repeat (ticks_to_report() + $urandom_range(0, 2)) begin
         send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   always @(posedge clock) begin : watch_rsp
      line_write_type got;
      line_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_write_enable, rsp_target_buffer, rsp_write_addr, rsp_write_data,
                rsp_event_res};
         if (pending_writes.size() == 0) begin
            bad_count++;
            if (bad_count <= 10) begin
               $display("unexpected result transfer: wen %0d buf %0d addr %0d data %h ev %0d",
                        got.wen, got.target, got.addr, got.data, got.ev);
            end
         end else begin
            want = pending_writes.pop_front();
            if (got.wen !== want.wen || got.target !== want.target ||
                got.addr !== want.addr || got.data !== want.data || got.ev !== want.ev) begin
               bad_count++;
               if (bad_count <= 10) begin
                  $display("mismatch: expected wen %0d buf %0d addr %0d data %h ev %0d",
                           want.wen, want.target, want.addr, want.data, want.ev);
                  $display("          actual   wen %0d buf %0d addr %0d data %h ev %0d",
                           got.wen, got.target, got.addr, got.data, got.ev);
               end
            end
         end
      end
   end

   initial begin
      int phase_start;
      int body_len;
      logic [7:0] reload_value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         send_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].fixed, DIRECTED[i].want);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         case (ph)
            0: reload_value = 8'd1;
            1: reload_value = 8'd0;
            2: reload_value = 8'd16;
            3: reload_value = 8'd2;
            4: reload_value = 8'($urandom_range(3, 40));
            default: reload_value = 8'd1;
         endcase
         write_reload(reload_value);
         // One phase runs with neither side idling.
         calm = (ph == 4);
         if (ph == 1) run_line(BUF_ANSWER, 258, 1'b1);
         if (ph == 4) run_line(BUF_PACKET, 260, 1'b1);
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 20) spray_noise();
            body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 12);
            run_line(1'($urandom_range(0, 1)), body_len, 1'b0);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (bad_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/arls_pkg.sv
rtl/core/arls_classify.sv
rtl/core/at_response_line_sorter.sv
test/tb.sv
